// ===== rtl/core/mohp_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Mandelbrot
// orbit-hit pixel core. No dependencies.
`timescale 1ns / 1ps

package mohp_pkg;

  // Fixed-point format: 4 integer bits, FRAC_BITS fraction bits
  localparam int FRAC_BITS   = 28;
  localparam int Q_W         = FRAC_BITS + 4;
  localparam int WIDE_W      = Q_W + 6;

  // Image and grid geometry
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int GRID_SCALE  = 10;
  localparam int ORBIT_MARKS = 20;
  localparam int ITER_LIMIT  = 1024;
  localparam int CELL_COUNT  = MAX_WIDTH * MAX_HEIGHT * GRID_SCALE * GRID_SCALE;
  localparam int CELL_W      = $clog2(CELL_COUNT);
  localparam int GW_W        = $clog2(MAX_WIDTH * GRID_SCALE + 1);
  localparam int GH2_W       = $clog2(2 * MAX_HEIGHT * GRID_SCALE + 1);
  localparam int ORB_IDX_W   = $clog2(ORBIT_MARKS);
  localparam int ORB_CNT_W   = $clog2(ORBIT_MARKS + 1);

  // Register file
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  // Result codes
  localparam logic [1:0] OUT_ESC = 2'd0;
  localparam logic [1:0] OUT_HIT = 2'd1;
  localparam logic [1:0] OUT_LIM = 2'd2;

  // Shared multiplier and divider widths
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DIV_W  = 8 + FRAC_BITS;
  localparam int DSR_W  = 11;

  // Visited-cell tags: a cell is marked when its tag equals the current epoch
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 4'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 4'd15;

  // Reciprocals for the divide by the 3 and 7 units of the plane spans
  localparam int RECIP_SH = 17;
  localparam logic [MUL_W-1:0] RECIP3 = 33'd43691;
  localparam logic [MUL_W-1:0] RECIP7 = 33'd18725;

  // Plane offsets and escape bound, wide signed
  localparam logic signed [WIDE_W-1:0] RE_LOW  = -(WIDE_W'(2) << FRAC_BITS);
  localparam logic signed [WIDE_W-1:0] IM_LOW  = -(WIDE_W'(7) << (FRAC_BITS - 2));
  localparam logic signed [WIDE_W-1:0] ESC_LIM = WIDE_W'(4) << FRAC_BITS;

  typedef struct packed {
    logic       new_image;
    logic [5:0] pixel_col;
    logic [5:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic [1:0] outcome;
  } pix_out_t;

  // Sign-extend a Q value to the wide format
  function automatic logic signed [WIDE_W-1:0] q_ext(input logic signed [Q_W-1:0] x);
    q_ext = $signed({{(WIDE_W - Q_W){x[Q_W-1]}}, x});
  endfunction

  // Saturate a wide value into the Q range
  function automatic logic signed [Q_W-1:0] q_sat(input logic signed [WIDE_W-1:0] v);
    logic hi_same;
    hi_same = (v[WIDE_W-1:Q_W-1] == '0) || (v[WIDE_W-1:Q_W-1] == '1);
    if (hi_same)
      q_sat = v[Q_W-1:0];
    else if (v[WIDE_W-1])
      q_sat = {1'b1, {(Q_W-1){1'b0}}};
    else
      q_sat = {1'b0, {(Q_W-1){1'b1}}};
  endfunction

  // Magnitude of a Q value as a multiplier operand
  function automatic logic [MUL_W-1:0] q_mag(input logic signed [Q_W-1:0] x);
    logic [Q_W-1:0] m;
    m = x[Q_W-1] ? (~x + 1'b1) : x;
    q_mag = MUL_W'(m);
  endfunction

  // Magnitude of a wide value, clipped to operand width
  function automatic logic [MUL_W-1:0] w_mag(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-1:0] m;
    m = x[WIDE_W-1] ? (~x + 1'b1) : x;
    w_mag = m[MUL_W-1:0];
  endfunction

  // Truncate a magnitude product to Q, apply sign, saturate
  function automatic logic signed [Q_W-1:0] q_fix(input logic [PROD_W-1:0] p,
                                                  input logic neg);
    logic [PROD_W-FRAC_BITS-1:0] mag;
    logic [Q_W-1:0]              low;
    mag = p[PROD_W-1:FRAC_BITS];
    low = mag[Q_W-1:0];
    if (mag[PROD_W-FRAC_BITS-1:Q_W-1] != '0)
      q_fix = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    else
      q_fix = neg ? $signed(~low + 1'b1) : $signed(low);
  endfunction

endpackage

// ===== rtl/core/mandelbrot_orbit_hit_pixel.sv =====
// Mandelbrot orbit-hit pixel core: sequencer around one shared multiplier,
// one shift-subtract divider and the visited-cell tag memory. Uses mohp_pkg.
`timescale 1ns / 1ps

// One pixel beat in, one result beat out. The core works on one pixel at a
// time: in_stall is high from accept until the result is loaded into the
// output register, which then waits for the sink while the next pixel runs.
// Orbit points, up to index max_iter, are computed one after another through
// the single shared multiplier; the serial divider runs twice for the start
// point and once for the intensity, and a hit or a limit stop adds the mark
// steps. A result still held by the sink delays the loading of the next one.
// Visited cells live in a 409600-entry tag memory; after reset, and on every
// 15th pixel flagged as a new image, a clearing pass over all entries runs
// before that pixel starts. Configuration writes are always taken (cfg_ready
// is tied high).
module mandelbrot_orbit_hit_pixel (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mohp_pkg::pix_in_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output mohp_pkg::pix_out_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mohp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mohp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [4:0] ST_CLR   = 5'd0;
  localparam logic [4:0] ST_IDLE  = 5'd1;
  localparam logic [4:0] ST_START = 5'd2;
  localparam logic [4:0] ST_DIV   = 5'd3;
  localparam logic [4:0] ST_CRSET = 5'd4;
  localparam logic [4:0] ST_CISET = 5'd5;
  localparam logic [4:0] ST_I0    = 5'd6;
  localparam logic [4:0] ST_I1    = 5'd7;
  localparam logic [4:0] ST_I2    = 5'd8;
  localparam logic [4:0] ST_P0    = 5'd9;
  localparam logic [4:0] ST_P1    = 5'd10;
  localparam logic [4:0] ST_P2    = 5'd11;
  localparam logic [4:0] ST_P3    = 5'd12;
  localparam logic [4:0] ST_P4    = 5'd13;
  localparam logic [4:0] ST_P5    = 5'd14;
  localparam logic [4:0] ST_P6    = 5'd15;
  localparam logic [4:0] ST_P7    = 5'd16;
  localparam logic [4:0] ST_P8    = 5'd17;
  localparam logic [4:0] ST_P9    = 5'd18;
  localparam logic [4:0] ST_MARK  = 5'd19;
  localparam logic [4:0] ST_INT   = 5'd20;
  localparam logic [4:0] ST_FIN   = 5'd21;

  localparam logic [1:0] JOB_CR  = 2'd0;
  localparam logic [1:0] JOB_CI  = 2'd1;
  localparam logic [1:0] JOB_INT = 2'd2;

  localparam int QW  = mohp_pkg::Q_W;
  localparam int WW  = mohp_pkg::WIDE_W;
  localparam int CW  = mohp_pkg::CELL_W;
  localparam int MW  = mohp_pkg::MUL_W;
  localparam int PW  = mohp_pkg::PROD_W;
  localparam int DW  = mohp_pkg::DIV_W;
  localparam int SW  = mohp_pkg::DSR_W;
  localparam int EW  = mohp_pkg::EPOCH_W;
  localparam int FB  = mohp_pkg::FRAC_BITS;
  localparam int GWW = mohp_pkg::GW_W;
  localparam int OIW = mohp_pkg::ORB_IDX_W;
  localparam int OCW = mohp_pkg::ORB_CNT_W;
  localparam int QXW = 15;

  // Control state
  logic [4:0]      state_r, state_nxt;
  logic [EW-1:0]   epoch_r, epoch_nxt;
  logic            resume_r, resume_nxt;
  logic [CW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [6:0]      width_r, height_r;
  logic [10:0]     maxit_r;

  // Datapath registers
  logic [5:0]            col_r, col_nxt, row_r, row_nxt;
  logic [DW-1:0]         dvd_r, dvd_nxt;
  logic [SW-1:0]         dsr_r, dsr_nxt, rem_r, rem_nxt;
  logic [5:0]            dcnt_r, dcnt_nxt;
  logic [1:0]            job_r, job_nxt;
  logic signed [QW-1:0]  cr_r, cr_nxt, ci_r, ci_nxt, re_r, re_nxt, im_r, im_nxt;
  logic signed [QW-1:0]  rr_r, rr_nxt, ii_r, ii_nxt;
  logic [10:0]           cnt_r, cnt_nxt, k_r, k_nxt;
  logic                  axneg_r, axneg_nxt, okx_r, okx_nxt, cell_ok_r, cell_ok_nxt;
  logic                  hit_r, hit_nxt;
  logic [GWW-1:0]        qx_r, qx_nxt;
  logic [1:0]            outc_r, outc_nxt;
  logic [OCW-1:0]        mk_n_r, mk_n_nxt;
  logic [OIW-1:0]        mk_j_r, mk_j_nxt;
  mohp_pkg::pix_out_t    out_data_r, out_data_nxt;

  // Shared multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic          mul_neg, neg_r;
  logic [PW-1:0] prod_r;

  // Tag memory and orbit cell list
  logic [EW-1:0] tag_mem [mohp_pkg::CELL_COUNT];
  logic [EW-1:0] rd_r;
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;
  logic [CW-1:0] orb_addr_r [mohp_pkg::ORBIT_MARKS];
  logic          orb_ok_r   [mohp_pkg::ORBIT_MARKS];
  logic          orb_we;

  // Clamped configuration
  logic [6:0]     w_cl, h_cl;
  logic [10:0]    mit_cl;
  logic [GWW-1:0] gw;
  logic [mohp_pkg::GH2_W-1:0] gh2;

  always_comb begin
    w_cl   = (width_r == '0) ? 7'd1 :
             (width_r > 7'(mohp_pkg::MAX_WIDTH)) ? 7'(mohp_pkg::MAX_WIDTH) : width_r;
    h_cl   = (height_r == '0) ? 7'd1 :
             (height_r > 7'(mohp_pkg::MAX_HEIGHT)) ? 7'(mohp_pkg::MAX_HEIGHT) : height_r;
    mit_cl = (maxit_r == '0) ? 11'd1 :
             (maxit_r > 11'(mohp_pkg::ITER_LIMIT)) ? 11'(mohp_pkg::ITER_LIMIT) : maxit_r;
    gw     = GWW'(w_cl * mohp_pkg::GRID_SCALE);
    gh2    = mohp_pkg::GH2_W'(h_cl * (2 * mohp_pkg::GRID_SCALE));
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Sequencer and datapath next state
  always_comb begin
    logic [SW:0]           rem_sh;
    logic [SW:0]           rem_diff;
    logic                  qbit;
    logic signed [WW-1:0]  dw;
    logic signed [QW-1:0]  ri, ii_c;
    logic [QXW-1:0]        qv;
    logic                  esc;
    logic [OCW-1:0]        olen;
    logic [18:0]           k255;
    logic [7:0]            col3;
    logic [8:0]            row7;

    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    resume_nxt    = resume_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    col_nxt = col_r;  row_nxt = row_r;
    dvd_nxt = dvd_r;  dsr_nxt = dsr_r;  rem_nxt = rem_r;
    dcnt_nxt = dcnt_r; job_nxt = job_r;
    cr_nxt = cr_r; ci_nxt = ci_r; re_nxt = re_r; im_nxt = im_r;
    rr_nxt = rr_r; ii_nxt = ii_r;
    cnt_nxt = cnt_r; k_nxt = k_r;
    axneg_nxt = axneg_r; okx_nxt = okx_r; cell_ok_nxt = cell_ok_r; hit_nxt = hit_r;
    qx_nxt = qx_r; outc_nxt = outc_r; mk_n_nxt = mk_n_r; mk_j_nxt = mk_j_r;
    mul_a = '0; mul_b = '0; mul_neg = 1'b0;
    mem_we = 1'b0; mem_wa = clr_addr_r; mem_wd = '0;
    mem_re = 1'b0; mem_ra = '0;
    orb_we = 1'b0;
    rem_sh = {rem_r, dvd_r[DW-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    qbit = 1'b0;
    dw = '0; ri = '0; ii_c = '0; qv = '0; esc = 1'b0; olen = '0;
    k255 = {k_r, 8'b0} - {8'b0, k_r};
    col3 = 8'(col_r) * 8'd3;
    row7 = 9'(row_r) * 9'd7;

    // Drop the result once the sink takes it
    if (out_valid_r && !out_stall)
      out_valid_nxt = 1'b0;

    case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        if (clr_addr_r == CW'(mohp_pkg::CELL_COUNT - 1)) begin
          epoch_nxt  = mohp_pkg::EPOCH_FIRST;
          resume_nxt = 1'b0;
          state_nxt  = resume_r ? ST_START : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          col_nxt = in_data.pixel_col;
          row_nxt = in_data.pixel_row;
          state_nxt = ST_START;
          if (in_data.new_image) begin
            if (epoch_r == mohp_pkg::EPOCH_LAST) begin
              clr_addr_nxt = '0;
              resume_nxt   = 1'b1;
              state_nxt    = ST_CLR;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      ST_START: begin
        dvd_nxt = {col3, {FB{1'b0}}};
        dsr_nxt = SW'(w_cl);
        rem_nxt = '0; dcnt_nxt = '0; job_nxt = JOB_CR;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle
        if (rem_sh >= {1'b0, dsr_r}) begin
          qbit = 1'b1;
          rem_nxt = rem_diff[SW-1:0];
        end else begin
          rem_nxt = rem_sh[SW-1:0];
        end
        dvd_nxt  = {dvd_r[DW-2:0], qbit};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'(DW - 1)) begin
          case (job_r)
            JOB_CR:  state_nxt = ST_CRSET;
            JOB_CI:  state_nxt = ST_CISET;
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_CRSET: begin
        cr_nxt  = mohp_pkg::q_sat($signed({2'b0, dvd_r}) + mohp_pkg::RE_LOW);
        dvd_nxt = {row7, {(FB - 1){1'b0}}};
        dsr_nxt = SW'(h_cl);
        rem_nxt = '0; dcnt_nxt = '0; job_nxt = JOB_CI;
        state_nxt = ST_DIV;
      end
      ST_CISET: begin
        ci_nxt = mohp_pkg::q_sat($signed({2'b0, dvd_r}) + mohp_pkg::IM_LOW);
        im_nxt = ci_nxt;
        re_nxt = cr_r;
        state_nxt = ST_I0;
      end
      ST_I0: begin
        mul_a = mohp_pkg::q_mag(re_r); mul_b = mohp_pkg::q_mag(re_r);
        state_nxt = ST_I1;
      end
      ST_I1: begin
        rr_nxt = mohp_pkg::q_fix(prod_r, neg_r);
        mul_a = mohp_pkg::q_mag(im_r); mul_b = mohp_pkg::q_mag(im_r);
        state_nxt = ST_I2;
      end
      ST_I2: begin
        ii_nxt = mohp_pkg::q_fix(prod_r, neg_r);
        cnt_nxt = '0;
        state_nxt = ST_P0;
      end
      ST_P0: begin
        mul_a = mohp_pkg::q_mag(re_r); mul_b = mohp_pkg::q_mag(im_r);
        mul_neg = re_r[QW-1] ^ im_r[QW-1];
        state_nxt = ST_P1;
      end
      ST_P1: begin
        // Advance z = z^2 + c
        ri = mohp_pkg::q_fix(prod_r, neg_r);
        re_nxt = mohp_pkg::q_sat(mohp_pkg::q_ext(rr_r) - mohp_pkg::q_ext(ii_r)
                                 + mohp_pkg::q_ext(cr_r));
        im_nxt = mohp_pkg::q_sat((mohp_pkg::q_ext(ri) <<< 1) + mohp_pkg::q_ext(ci_r));
        state_nxt = ST_P2;
      end
      ST_P2: begin
        dw = mohp_pkg::q_ext(re_r) - mohp_pkg::RE_LOW;
        mul_a = mohp_pkg::w_mag(dw); mul_b = MW'(gw);
        axneg_nxt = dw[WW-1];
        state_nxt = ST_P3;
      end
      ST_P3: begin
        mul_a = MW'(prod_r[FB+16:FB]); mul_b = mohp_pkg::RECIP3;
        state_nxt = ST_P4;
      end
      ST_P4: begin
        qv = prod_r[mohp_pkg::RECIP_SH+QXW-1:mohp_pkg::RECIP_SH];
        okx_nxt = (qv < QXW'(gw)) && !(axneg_r && (qv != '0));
        qx_nxt  = qv[GWW-1:0];
        dw = mohp_pkg::q_ext(im_r) - mohp_pkg::IM_LOW;
        mul_a = mohp_pkg::w_mag(dw); mul_b = MW'(gh2);
        axneg_nxt = dw[WW-1];
        state_nxt = ST_P5;
      end
      ST_P5: begin
        mul_a = MW'(prod_r[FB+16:FB]); mul_b = mohp_pkg::RECIP7;
        state_nxt = ST_P6;
      end
      ST_P6: begin
        qv = prod_r[mohp_pkg::RECIP_SH+QXW-1:mohp_pkg::RECIP_SH];
        cell_ok_nxt = okx_r && (qv < QXW'(gh2 >> 1)) && !(axneg_r && (qv != '0));
        mul_a = MW'(qv[GWW-1:0]); mul_b = MW'(gw);
        state_nxt = ST_P7;
      end
      ST_P7: begin
        // Look up the cell and, for the first ORBIT_MARKS points, log it for marking
        mem_ra = prod_r[CW-1:0] + CW'(qx_r);
        mem_re = 1'b1;
        orb_we = (cnt_r < 11'(mohp_pkg::ORBIT_MARKS));
        mul_a = mohp_pkg::q_mag(re_r); mul_b = mohp_pkg::q_mag(re_r);
        state_nxt = ST_P8;
      end
      ST_P8: begin
        rr_nxt  = mohp_pkg::q_fix(prod_r, neg_r);
        hit_nxt = cell_ok_r && (rd_r == epoch_r);
        mul_a = mohp_pkg::q_mag(im_r); mul_b = mohp_pkg::q_mag(im_r);
        state_nxt = ST_P9;
      end
      ST_P9: begin
        ii_c   = mohp_pkg::q_fix(prod_r, neg_r);
        ii_nxt = ii_c;
        esc = (mohp_pkg::q_ext(rr_r) + mohp_pkg::q_ext(ii_c)) > mohp_pkg::ESC_LIM;
        olen = (cnt_r >= 11'(mohp_pkg::ORBIT_MARKS - 1)) ? OCW'(mohp_pkg::ORBIT_MARKS)
                                                         : OCW'(cnt_r) + 1'b1;
        mk_n_nxt = (11'(olen) < mit_cl) ? olen : OCW'(mit_cl);
        mk_j_nxt = '0;
        if (hit_r) begin
          k_nxt = 11'd1; outc_nxt = mohp_pkg::OUT_HIT; state_nxt = ST_MARK;
        end else if (esc) begin
          k_nxt = cnt_r; outc_nxt = mohp_pkg::OUT_ESC; state_nxt = ST_INT;
        end else if (cnt_r >= mit_cl) begin
          k_nxt = 11'd2; outc_nxt = mohp_pkg::OUT_LIM; state_nxt = ST_MARK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = ST_P0;
        end
      end
      ST_MARK: begin
        // Mark the logged cells of this orbit, one per cycle
        if (OCW'(mk_j_r) < mk_n_r) begin
          mem_we = orb_ok_r[mk_j_r];
          mem_wa = orb_addr_r[mk_j_r];
          mem_wd = epoch_r;
          mk_j_nxt = mk_j_r + 1'b1;
        end else begin
          state_nxt = ST_INT;
        end
      end
      ST_INT: begin
        dvd_nxt = DW'(k255);
        dsr_nxt = mit_cl;
        rem_nxt = '0; dcnt_nxt = '0; job_nxt = JOB_INT;
        state_nxt = ST_DIV;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.intensity = dvd_r[7:0];
          out_data_nxt.outcome   = outc_r;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      epoch_r     <= '0;
      resume_r    <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      width_r     <= 7'(mohp_pkg::MAX_WIDTH);
      height_r    <= 7'(mohp_pkg::MAX_HEIGHT);
      maxit_r     <= 11'd256;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      resume_r    <= resume_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          mohp_pkg::REG_WIDTH:    width_r  <= cfg_wdata[6:0];
          mohp_pkg::REG_HEIGHT:   height_r <= cfg_wdata[6:0];
          mohp_pkg::REG_MAX_ITER: maxit_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    col_r <= col_nxt;  row_r <= row_nxt;
    dvd_r <= dvd_nxt;  dsr_r <= dsr_nxt;  rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt; job_r <= job_nxt;
    cr_r <= cr_nxt; ci_r <= ci_nxt; re_r <= re_nxt; im_r <= im_nxt;
    rr_r <= rr_nxt; ii_r <= ii_nxt;
    cnt_r <= cnt_nxt; k_r <= k_nxt;
    axneg_r <= axneg_nxt; okx_r <= okx_nxt; cell_ok_r <= cell_ok_nxt; hit_r <= hit_nxt;
    qx_r <= qx_nxt; outc_r <= outc_nxt; mk_n_r <= mk_n_nxt; mk_j_r <= mk_j_nxt;
    out_data_r <= out_data_nxt;
    prod_r <= PW'(mul_a) * PW'(mul_b);
    neg_r  <= mul_neg;
  end

  // Orbit cell list
  always_ff @(posedge clk) begin
    if (orb_we) begin
      orb_addr_r[cnt_r[OIW-1:0]] <= mem_ra;
      orb_ok_r[cnt_r[OIW-1:0]]   <= cell_ok_r;
    end
  end

  // Visited-cell tag memory
  always_ff @(posedge clk) begin
    if (mem_we)
      tag_mem[mem_wa] <= mem_wd;
    if (mem_re)
      rd_r <= tag_mem[mem_ra];
  end

`ifndef SYNTHESIS
  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CLR) |-> (epoch_r != '0))
    else $error("epoch zero outside clearing pass");

  a_mark_only_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK && mem_we) |-> (outc_r != mohp_pkg::OUT_ESC))
    else $error("escaped orbit marks cells");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P0) |-> (cnt_r <= mit_cl))
    else $error("iteration count past limit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_START || state_r == ST_CLR))
    else $error("accepted pixel not started");

  a_mark_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (mk_n_r <= OCW'(mohp_pkg::ORBIT_MARKS)))
    else $error("mark count too large");
`endif

endmodule
